[rtl/rmtd_pkg.sv]
package rmtd_pkg;

    localparam int DATA_W     = 8;
    localparam int SIZE_W     = 21;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam logic [SIZE_W-1:0] MIN_SIZE_RST = 21'd16384;
    localparam logic [DATA_W-1:0] FILL_BYTE    = 8'hFF;

    // Source of the size that is reported for an image.
    typedef enum logic [1:0] {
        RES_SPAN = 2'd0,
        RES_SIZE = 2'd1,
        RES_MIN  = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic     load_wr;
        logic     load_end;
        logic     run_init;
        logic     cmp_mode;
        logic     run_en;
        logic     halve;
        logic     res_wr;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic lvl_go;
        logic chk_valid;
        logic chk_ok;
        logic chk_last;
    } stat_t;

endpackage

[rtl/rmtd_ctrl.sv]
module rmtd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_tlast,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  rmtd_pkg::stat_t stat,
    output rmtd_pkg::cmd_t  cmd
);
    import rmtd_pkg::*;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_LEVEL = 5'b00010,
        ST_SPAN  = 5'b00100,
        ST_FFCHK = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.res_sel    = RES_SIZE;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    cmd.load_wr = 1'b1;
                    if (s_tlast) begin
                        cmd.load_end = 1'b1;
                        state_next   = ST_LEVEL;
                    end
                end
            end
            ST_LEVEL: begin
                // The mode chosen here is latched by the datapath for the whole run.
                cmd.run_init = 1'b1;
                cmd.cmp_mode = stat.lvl_go;
                state_next   = stat.lvl_go ? ST_SPAN : ST_FFCHK;
            end
            ST_SPAN: begin
                cmd.run_en = 1'b1;
                if (stat.chk_valid) begin
                    if (!stat.chk_ok) begin
                        cmd.res_wr  = 1'b1;
                        cmd.res_sel = RES_SPAN;
                        state_next  = ST_DONE;
                    end else if (stat.chk_last) begin
                        cmd.halve  = 1'b1;
                        state_next = ST_LEVEL;
                    end
                end
            end
            ST_FFCHK: begin
                cmd.run_en = 1'b1;
                if (stat.chk_valid) begin
                    if (!stat.chk_ok) begin
                        cmd.res_wr  = 1'b1;
                        cmd.res_sel = RES_MIN;
                        state_next  = ST_DONE;
                    end else if (stat.chk_last) begin
                        cmd.res_wr  = 1'b1;
                        cmd.res_sel = RES_SIZE;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = out_valid_reg;

endmodule

[rtl/rmtd_datapath.sv]
module rmtd_datapath #(
    parameter int MAX_IMAGE_BYTES = 1048576
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [rmtd_pkg::SIZE_W-1:0]      cfg_wr_data,
    input  logic [rmtd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  rmtd_pkg::cmd_t                   cmd,
    output rmtd_pkg::stat_t                  stat,
    output logic [rmtd_pkg::M_TDATA_W-1:0]   m_tdata
);
    import rmtd_pkg::*;

    localparam int AW = $clog2(MAX_IMAGE_BYTES);
    localparam int CW = $clog2(MAX_IMAGE_BYTES + 1);
    localparam int XW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_IMAGE_BYTES);

    logic [DATA_W-1:0] mem [MAX_IMAGE_BYTES];

    logic [SIZE_W-1:0]    min_size_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        size_reg;
    logic [CW-1:0]        half_reg;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        bound_reg;
    logic                 mode_reg;
    logic                 pend_reg;
    logic                 pend_last_reg;
    logic [DATA_W-1:0]    rd_a_reg;
    logic [DATA_W-1:0]    rd_b_reg;
    logic [XW-1:0]        res_reg;
    logic                 err_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [SIZE_W-1:0] minv;
    logic [XW-1:0]     minv_x;
    logic [XW-1:0]     half_x;
    logic [XW-1:0]     size_x;
    logic [XW-1:0]     tested_x;
    logic              cnt_sat;
    logic [CW-1:0]     count_inc;
    logic [CW-1:0]     size_new;
    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     span_addr;
    logic              issue;

    // A minimum of zero behaves as one.
    assign minv     = (min_size_reg == '0) ? SIZE_W'(1) : min_size_reg;
    assign minv_x   = XW'(minv);
    assign half_x   = XW'(half_reg);
    assign size_x   = XW'(size_reg);
    assign tested_x = (minv_x < size_x) ? minv_x : size_x;

    assign cnt_sat   = (count_reg == MAX_CNT);
    assign count_inc = count_reg + CW'(1);
    assign size_new  = cnt_sat ? count_reg : count_inc;
    assign idx_inc   = idx_reg + CW'(1);
    assign span_addr = half_reg + idx_reg;
    assign issue     = cmd.run_en && (idx_reg < bound_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_size_reg <= MIN_SIZE_RST;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                min_size_reg <= cfg_wr_data;
            end
            if (cmd.load_end) begin
                count_reg <= '0;
            end else if (cmd.load_wr && !cnt_sat) begin
                count_reg <= count_inc;
            end
            pend_reg <= cmd.run_init ? 1'b0 : issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && !cnt_sat) begin
            mem[count_reg[AW-1:0]] <= s_tdata;
        end
        rd_a_reg <= mem[idx_reg[AW-1:0]];
        rd_b_reg <= mem[span_addr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_end) begin
            size_reg <= size_new;
            half_reg <= size_new >> 1;
        end else if (cmd.halve) begin
            half_reg <= half_reg >> 1;
        end
        if (cmd.run_init) begin
            idx_reg   <= '0;
            bound_reg <= cmd.cmp_mode ? half_reg : CW'(tested_x);
            mode_reg  <= cmd.cmp_mode;
        end else if (issue) begin
            idx_reg <= idx_inc;
        end
        pend_last_reg <= (idx_inc == bound_reg);
        if (cmd.res_wr) begin
            case (cmd.res_sel)
                RES_SPAN: begin
                    res_reg <= half_x << 1;
                    err_reg <= 1'b0;
                end
                RES_SIZE: begin
                    res_reg <= size_x;
                    err_reg <= 1'b1;
                end
                RES_MIN: begin
                    res_reg <= minv_x;
                    err_reg <= 1'b0;
                end
                default: begin
                    res_reg <= size_x;
                    err_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.out_load) begin
            out_data_reg <= {1'b0, err_reg, (res_reg != size_x), res_reg[SIZE_W-1:0]};
        end
    end

    assign stat.lvl_go    = (half_x >= minv_x);
    assign stat.chk_valid = pend_reg;
    assign stat.chk_ok    = mode_reg ? (rd_a_reg == rd_b_reg) : (rd_a_reg == FILL_BYTE);
    assign stat.chk_last  = pend_last_reg;

    assign m_tdata = out_data_reg;

endmodule

[rtl/rom_mirror_trim_detector.sv]
// Loading takes one word per cycle; the word marked tlast starts the size search.
// Search: each halving level compares the bytes below half with those above it; if no level differs,
// the 0xFF test checks min(min_size, size) bytes, and then the result moves to the output register.
// The search reads the image memory through two registered read ports, one byte pair a cycle.
// s_tready is low from the last word until the result is in the output register.
// Synchronous active-low reset: control and count cleared, min_size 16384, memory kept.
module rom_mirror_trim_detector #(
    parameter int MAX_IMAGE_BYTES = 1048576
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [rmtd_pkg::SIZE_W-1:0]      cfg_wr_data,   // min_size
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rmtd_pkg::S_TDATA_W-1:0]   s_tdata,       // [7:0] data_byte
    input  logic                             s_tlast,       // last_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rmtd_pkg::M_TDATA_W-1:0]   m_tdata        // [20:0] true_size, [21] size_changed,
                                                            // [22] all_ff_error, [23] zero
);
    import rmtd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rmtd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rmtd_datapath #(
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .m_tdata     (m_tdata)
    );

endmodule

[rtl/rmtd_checker.sv]
module rmtd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rmtd_pkg::M_TDATA_W-1:0] m_tdata
);
    import rmtd_pkg::*;

    // A pending result word is held until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    // The search begins right after the last word, so input is closed off.
    a_search_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input accepted during size search");

    // An all-0xFF image keeps its loaded size.
    a_err_keeps_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[SIZE_W+1] |-> !m_tdata[SIZE_W])
        else $error("error result reports a changed size");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[M_TDATA_W-1])
        else $error("padding bit set in result word");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind rom_mirror_trim_detector rmtd_checker u_rmtd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/tb.sv]
module tb;
    import rmtd_pkg::*;

    // A small image memory keeps the simulation light.
    localparam int unsigned IMG_BYTES     = 16384;
    localparam int unsigned LIMIT_CYCLES  = 1000000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned PHASE_WORDS   = 70;

    typedef struct packed {
        logic [SIZE_W-1:0] true_size;
        logic              size_changed;
        logic              all_ff_error;
    } trim_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [SIZE_W-1:0]    cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [DATA_W-1:0] img_mem [IMG_BYTES];
    int unsigned       img_len;
    logic [SIZE_W-1:0] min_size_now;
    logic [DATA_W-1:0] img_words [$];
    trim_result_t      pending_trims [$];
    int unsigned       words_sent;
    int unsigned       errors;
    int unsigned       cycles;
    int unsigned       rx_hold_req;
    int unsigned       rx_hold_left;
    bit                steady;

    rom_mirror_trim_detector #(
        .MAX_IMAGE_BYTES(IMG_BYTES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Works out the size report for the image of n bytes now held in img_mem.
    function automatic trim_result_t predict_trim(input int unsigned n);
        trim_result_t r;
        int unsigned  floor_sz;
        int unsigned  half;
        int unsigned  size_out;
        int unsigned  tested;
        bit           differ;
        bit           all_ff;
        floor_sz = (min_size_now == 0) ? 1 : min_size_now;
        half = n / 2;
        size_out = 0;
        r.all_ff_error = 1'b0;
        while (half >= floor_sz && size_out == 0) begin
            differ = 1'b0;
            for (int unsigned i = 0; i < half; i++) begin
                if (img_mem[i] != img_mem[half + i])
                    differ = 1'b1;
            end
            if (differ)
                size_out = half * 2;
            else
                half = half / 2;
        end
        if (size_out == 0) begin
            tested = (floor_sz < n) ? floor_sz : n;
            all_ff = 1'b1;
            for (int unsigned i = 0; i < tested; i++) begin
                if (img_mem[i] != FILL_BYTE)
                    all_ff = 1'b0;
            end
            if (all_ff) begin
                r.all_ff_error = 1'b1;
                size_out = n;
            end else begin
                size_out = floor_sz;
            end
        end
        r.true_size = size_out[SIZE_W-1:0];
        r.size_changed = (size_out != n);
        return r;
    endfunction

    task automatic send_word(input logic [DATA_W-1:0] d, input logic l);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        if (img_len < IMG_BYTES) begin
            img_mem[img_len] = d;
            img_len++;
        end
        if (l) begin
            pending_trims.push_back(predict_trim(img_len));
            img_len = 0;
        end
        if (!steady && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic send_image();
        foreach (img_words[i])
            send_word(img_words[i], i == img_words.size() - 1);
        img_words.delete();
    endtask

    // Appends copies of one random pattern; ff_share is the chance in 100 that a byte is forced to 0xFF.
    task automatic add_mirrored(input int period, input int copies, input int ff_share);
        logic [DATA_W-1:0] pat [$];
        for (int i = 0; i < period; i++)
            pat.push_back(($urandom_range(99) < ff_share) ? FILL_BYTE
                                                          : DATA_W'($urandom_range(255)));
        for (int c = 0; c < copies; c++)
            foreach (pat[i]) img_words.push_back(pat[i]);
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (pending_trims.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_min_size(input logic [SIZE_W-1:0] v);
        wait_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        min_size_now = v;
    endtask

    // The reset minimum of 16384 only ever sees short images here.
    task automatic test_reset_min_size();
        img_words = '{8'h12, 8'h00, 8'hFF, 8'h80, 8'h7F};
        send_image();
        img_words = '{8'hFF, 8'hFF, 8'hFF};
        send_image();
        img_words = '{8'h00};
        send_image();
        img_words = '{8'hFF};
        send_image();
        wait_results();
    endtask

    task automatic test_mirror_search();
        write_min_size(21'd4);
        add_mirrored(8, 8, 0);
        send_image();
        add_mirrored(4, 16, 0);
        send_image();
        add_mirrored(16, 1, 0);
        send_image();
        add_mirrored(12, 2, 0);
        send_image();
        // A single bad byte in the top copy must stop the search at the first level.
        add_mirrored(8, 8, 0);
        img_words[60] = img_words[60] ^ 8'h01;
        send_image();
        wait_results();
    endtask

    task automatic test_all_ff();
        write_min_size(21'd4);
        add_mirrored(16, 1, 100);
        send_image();
        img_words = '{8'hFF, 8'hFF};
        send_image();
        img_words = '{8'hFF, 8'h00};
        send_image();
        add_mirrored(32, 1, 100);
        img_words[20] = 8'hFE;
        send_image();
        wait_results();
    endtask

    task automatic test_zero_min();
        write_min_size(21'd0);
        img_words = '{8{8'h5A}};
        send_image();
        img_words = '{8'h33};
        send_image();
        img_words = '{8'hFF};
        send_image();
        wait_results();
    endtask

    task automatic test_large_min();
        write_min_size(21'd1048576);
        add_mirrored(6, 1, 0);
        send_image();
        write_min_size(21'd1048575);
        add_mirrored(5, 1, 100);
        send_image();
        add_mirrored(7, 1, 30);
        send_image();
        wait_results();
    endtask

    task automatic test_backpressure();
        write_min_size(21'd2);
        rx_hold_req = HOLD_CYCLES;
        for (int k = 0; k < 6; k++) begin
            add_mirrored(2, 4, 20);
            send_image();
        end
        wait_results();
    endtask

    task automatic test_pause();
        write_min_size(21'd4);
        add_mirrored(8, 4, 10);
        send_image();
        wait_results();
        add_mirrored(4, 8, 10);
        send_image();
        wait_results();
    endtask

    task automatic send_random_image();
        int kind;
        int period;
        int copies;
        int n;
        kind = $urandom_range(99);
        if (kind < 60) begin
            period = 1 << $urandom_range(0, 4);
            if ($urandom_range(3) == 0)
                period = $urandom_range(1, 16);
            copies = 1 << $urandom_range(0, 3);
            add_mirrored(period, copies, 20);
            if ($urandom_range(2) == 0) begin
                n = $urandom_range(0, img_words.size() - 1);
                img_words[n] = img_words[n] ^ DATA_W'($urandom_range(1, 255));
            end
        end else if (kind < 78) begin
            n = ($urandom_range(1) == 0) ? (1 << $urandom_range(0, 5)) : $urandom_range(1, 32);
            add_mirrored(n, 1, 100);
            if ($urandom_range(2) == 0)
                img_words[$urandom_range(0, n - 1)] = DATA_W'($urandom_range(255));
        end else begin
            add_mirrored($urandom_range(1, 40), 1, 5);
        end
        send_image();
    endtask

    task automatic test_random_images();
        logic [SIZE_W-1:0] floors [7];
        int unsigned       stop_at;
        floors = '{21'd1, 21'd4, 21'd16, 21'd2, 21'd0, 21'd8, 21'd1048575};
        for (int p = 0; p < 7; p++) begin
            write_min_size(floors[p]);
            steady = (p == 2);
            stop_at = words_sent + PHASE_WORDS;
            while (words_sent < stop_at)
                send_random_image();
        end
        wait_results();
        steady = 1'b0;
    endtask

    // The hold-off is counted here so that the sender can keep offering words.
    always @(posedge aclk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 26);
        end
    end

    always @(posedge aclk) begin
        trim_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_trims.size() == 0) begin
                $error("result word with no image pending: m_tdata %h", m_tdata);
                errors++;
            end else begin
                want = pending_trims.pop_front();
                if (m_tdata[SIZE_W-1:0] !== want.true_size) begin
                    $error("true_size: expected %0d, got %0d", want.true_size,
                           m_tdata[SIZE_W-1:0]);
                    errors++;
                end
                if (m_tdata[SIZE_W] !== want.size_changed) begin
                    $error("size_changed: expected %0b, got %0b", want.size_changed,
                           m_tdata[SIZE_W]);
                    errors++;
                end
                if (m_tdata[SIZE_W+1] !== want.all_ff_error) begin
                    $error("all_ff_error: expected %0b, got %0b", want.all_ff_error,
                           m_tdata[SIZE_W+1]);
                    errors++;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: errors");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        steady = 1'b0;
        rx_hold_req = 0;
        rx_hold_left = 0;
        words_sent = 0;
        errors = 0;
        img_len = 0;
        min_size_now = MIN_SIZE_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_min_size();
        test_mirror_search();
        test_all_ff();
        test_zero_min();
        test_large_min();
        test_backpressure();
        test_pause();
        test_random_images();

        wait_results();
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

[filelist.f]
rtl/rmtd_pkg.sv
rtl/rmtd_ctrl.sv
rtl/rmtd_datapath.sv
rtl/rom_mirror_trim_detector.sv
rtl/rmtd_checker.sv
tb/sv/tb.sv
